### design/gbm_pkg.sv
// ----------------------------------------------------------------------------
// gbm_pkg - shared constants for the Box-Muller Gaussian generator
// CORDIC arctangent table in 2^-32 turn, gain and log constants.
// ----------------------------------------------------------------------------
package gbm_pkg;

  localparam int CordicSteps = 30;
  localparam logic [31:0] CordicGain = 32'd2608131496;
  localparam logic [31:0] TwoLn2 = 32'd1488522236;

  typedef logic [29:0] atan_t;

  function automatic atan_t atan_turn(input logic [4:0] i);
    atan_t a;
    unique case (i)
      5'd0:  a = 30'h20000000;
      5'd1:  a = 30'h12E4051E;
      5'd2:  a = 30'h09FB385B;
      5'd3:  a = 30'h051111D4;
      5'd4:  a = 30'h028B0D43;
      5'd5:  a = 30'h0145D7E1;
      5'd6:  a = 30'h00A2F61E;
      5'd7:  a = 30'h00517C55;
      5'd8:  a = 30'h0028BE53;
      5'd9:  a = 30'h00145F2F;
      5'd10: a = 30'h000A2F98;
      5'd11: a = 30'h000517CC;
      5'd12: a = 30'h00028BE6;
      5'd13: a = 30'h000145F3;
      5'd14: a = 30'h0000A2FA;
      5'd15: a = 30'h0000517D;
      5'd16: a = 30'h000028BE;
      5'd17: a = 30'h0000145F;
      5'd18: a = 30'h00000A30;
      5'd19: a = 30'h00000518;
      5'd20: a = 30'h0000028C;
      5'd21: a = 30'h00000146;
      5'd22: a = 30'h000000A3;
      5'd23: a = 30'h00000051;
      5'd24: a = 30'h00000029;
      5'd25: a = 30'h00000014;
      5'd26: a = 30'h0000000A;
      5'd27: a = 30'h00000005;
      5'd28: a = 30'h00000003;
      5'd29: a = 30'h00000001;
      default: a = 30'h0;
    endcase
    return a;
  endfunction

endpackage

### design/gaussian_box_muller.sv
// ----------------------------------------------------------------------------
// gaussian_box_muller - fixed-point Box-Muller Gaussian sample generator
// sample = mean + sigma*sqrt(-2 ln u1)*cos(2 pi u2), Q16.16; u1 == 0 rejects.
//
//   channel  signals                                         dir
//   in       in_valid in_stall uniform_radius uniform_angle   in
//            mean sigma
//   out      out_valid out_stall sample rejected              out
//
// One beat per cycle unless the pipeline is stalled; 92 stages: normalise,
// 24 log squarings, scale multiply, 32 root steps, gain multiply, 30 CORDIC
// steps, quadrant, sigma multiply and mean add, one step per stage.
// Synchronous reset clears every valid bit.
// A stall on out freezes the whole pipeline unless its last slot is empty;
// in_stall is then raised, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module gaussian_box_muller
  import gbm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        uniform_radius,
  input  logic [31:0]        uniform_angle,
  input  logic signed [23:0] mean,
  input  logic [23:0]        sigma,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] sample,
  output logic               rejected
);

  localparam int LogSteps = 24;
  localparam int RootSteps = 32;

  // Common side payload: rejected, angle, mean, sigma
  localparam int SideW = 1 + 32 + 24 + 24;

  logic advance;
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // ---- stage 0: normalise u1 ----
  logic [SideW-1:0] side_in;
  assign side_in = {(uniform_radius == 32'd0), uniform_angle, mean, sigma};

  logic [5:0]  lz;
  logic [32:0] y_norm;
  always_comb begin
    lz = 6'd0;
    for (int b = 0; b < 32; b++) begin
      if (uniform_radius[b]) lz = 6'(31 - b);
    end
    y_norm = {1'b0, uniform_radius << lz};
  end

  // log pipeline payload: int part (6) + frac (24) + y (33) + side
  localparam int LogW = 6 + 24 + 33 + SideW;
  logic [LogW-1:0] lg_d [LogSteps+1];
  logic            lg_v [LogSteps+1];

  gbm_stage #(.Width(LogW)) u_norm (
    .clk(clk), .rst(rst), .advance(advance), .valid_in(in_valid),
    .data_in({6'(lz + 6'd1), 24'd0, y_norm, side_in}),
    .valid_out(lg_v[0]), .data_out(lg_d[0])
  );

  for (genvar k = 0; k < LogSteps; k++) begin : g_log
    logic [5:0]  ip;
    logic [23:0] fr, fr_n;
    logic [32:0] y;
    logic [65:0] sq;
    logic [32:0] y_n;
    logic [SideW-1:0] sd;
    always_comb begin
      {ip, fr, y, sd} = lg_d[k];
      sq = y * y;
      y_n = sq[63:31];
      fr_n = fr;
      if (y_n[32]) begin
        y_n = y_n >> 1;
        fr_n[LogSteps-1-k] = 1'b1;
      end
    end
    gbm_stage #(.Width(LogW)) u_st (
      .clk(clk), .rst(rst), .advance(advance), .valid_in(lg_v[k]),
      .data_in({ip, fr_n, y_n, sd}), .valid_out(lg_v[k+1]),
      .data_out(lg_d[k+1])
    );
  end

  // ---- R = (L * 2ln2 + 2^25) >> 26, Q6.28 ----
  localparam int RW = 36;
  logic [5:0]  l_ip;
  logic [23:0] l_fr, l_dummy_fr;
  logic [32:0] l_y;
  logic [SideW-1:0] l_sd;
  logic [29:0] l_val;
  logic [61:0] r_prod;
  always_comb begin
    {l_ip, l_fr, l_y, l_sd} = lg_d[LogSteps];
    l_dummy_fr = l_fr;
    l_val = {l_ip, 24'd0} - {6'd0, l_dummy_fr};
    r_prod = l_val * TwoLn2 + 62'(1) * (62'd1 << 25);
  end

  // root pipeline: rem (66), root (33), v shifted source (64), side
  localparam int RtW = 66 + 33 + 64 + SideW;
  logic [RtW-1:0] rt_d [RootSteps+1];
  logic           rt_v [RootSteps+1];
  logic [63:0]    r_shift;
  assign r_shift = 64'(r_prod[61:26]) << 28;

  gbm_stage #(.Width(RtW)) u_scale (
    .clk(clk), .rst(rst), .advance(advance), .valid_in(lg_v[LogSteps]),
    .data_in({66'd0, 33'd0, r_shift, l_sd}), .valid_out(rt_v[0]),
    .data_out(rt_d[0])
  );

  // restoring root, two radicand bits per step, MSB first
  for (genvar k = 0; k < RootSteps; k++) begin : g_root
    logic [65:0] rem, rem_n, trial;
    logic [32:0] root, root_n;
    logic [63:0] v;
    logic [SideW-1:0] sd;
    always_comb begin
      {rem, root, v, sd} = rt_d[k];
      rem_n = {rem[63:0], v[63:62]};
      trial = {root[31:0], 2'b01};
      if (rem_n >= trial) begin
        rem_n = rem_n - trial;
        root_n = {root[31:0], 1'b1};
      end else begin
        root_n = {root[31:0], 1'b0};
      end
    end
    gbm_stage #(.Width(RtW)) u_st (
      .clk(clk), .rst(rst), .advance(advance), .valid_in(rt_v[k]),
      .data_in({rem_n, root_n, v << 2, sd}), .valid_out(rt_v[k+1]),
      .data_out(rt_d[k+1])
    );
  end

  // ---- x0 = (S * gain + 2^31) >> 32 ----
  logic [65:0] s_rem;
  logic [32:0] s_root;
  logic [63:0] s_v;
  logic [SideW-1:0] s_sd;
  logic [64:0] x0_prod;
  always_comb begin
    {s_rem, s_root, s_v, s_sd} = rt_d[RootSteps];
    x0_prod = 65'(s_root[31:0]) * 65'(CordicGain) + (65'd1 << 31);
  end

  // CORDIC: x, y (36 signed), z (32 signed), side
  localparam int CW = 36 + 36 + 32 + SideW;
  logic [CW-1:0] cr_d [CordicSteps+1];
  logic          cr_v [CordicSteps+1];

  gbm_stage #(.Width(CW)) u_gain (
    .clk(clk), .rst(rst), .advance(advance), .valid_in(rt_v[RootSteps]),
    .data_in({36'(x0_prod[64:32]), 36'd0, {2'b00, s_sd[SideW-4 -: 30]}, s_sd}),
    .valid_out(cr_v[0]), .data_out(cr_d[0])
  );

  for (genvar k = 0; k < CordicSteps; k++) begin : g_cordic
    logic signed [35:0] x, y, x_n, y_n;
    logic signed [31:0] z, z_n;
    logic [SideW-1:0] sd;
    always_comb begin
      {x, y, z, sd} = cr_d[k];
      if (z >= 0) begin
        x_n = x - (y >>> k);
        y_n = y + (x >>> k);
        z_n = z - $signed({2'b00, atan_turn(5'(k))});
      end else begin
        x_n = x + (y >>> k);
        y_n = y - (x >>> k);
        z_n = z + $signed({2'b00, atan_turn(5'(k))});
      end
    end
    gbm_stage #(.Width(CW)) u_st (
      .clk(clk), .rst(rst), .advance(advance), .valid_in(cr_v[k]),
      .data_in({x_n, y_n, z_n, sd}), .valid_out(cr_v[k+1]),
      .data_out(cr_d[k+1])
    );
  end

  // ---- quadrant select ----
  logic signed [35:0] q_x, q_y, q_c;
  logic signed [31:0] q_z;
  logic [SideW-1:0]   q_sd;
  always_comb begin
    {q_x, q_y, q_z, q_sd} = cr_d[CordicSteps];
    unique case (q_sd[SideW-2 -: 2])
      2'd0:    q_c = q_x;
      2'd1:    q_c = -q_y;
      2'd2:    q_c = -q_x;
      default: q_c = q_y;
    endcase
  end

  localparam int QW = 36 + SideW;
  logic [QW-1:0] qd;
  logic          qv;
  gbm_stage #(.Width(QW)) u_quad (
    .clk(clk), .rst(rst), .advance(advance), .valid_in(cr_v[CordicSteps]),
    .data_in({q_c, q_sd}), .valid_out(qv), .data_out(qd)
  );

  // ---- sigma * C ----
  logic signed [35:0] m_c;
  logic [SideW-1:0]   m_sd;
  logic signed [60:0] m_prod;
  always_comb begin
    {m_c, m_sd} = qd;
    m_prod = 61'(m_c) * $signed({37'd0, m_sd[23:0]}) + (61'sd1 <<< 27);
  end

  localparam int MW = 61 + SideW;
  logic [MW-1:0] md;
  logic          mv;
  gbm_stage #(.Width(MW)) u_mul (
    .clk(clk), .rst(rst), .advance(advance), .valid_in(qv),
    .data_in({m_prod, m_sd}), .valid_out(mv), .data_out(md)
  );

  // ---- mean add, output register ----
  logic signed [60:0] a_prod;
  logic [SideW-1:0]   a_sd;
  logic signed [31:0] a_sum;
  logic               a_rej;
  always_comb begin
    {a_prod, a_sd} = md;
    a_rej = a_sd[SideW-1];
    a_sum = 32'($signed(a_sd[47:24])) + a_prod[59:28];
    if (a_rej) a_sum = 32'sd0;
  end

  logic [32:0] o_d;
  gbm_stage #(.Width(33)) u_out (
    .clk(clk), .rst(rst), .advance(advance), .valid_in(mv),
    .data_in({a_rej, a_sum}), .valid_out(out_valid), .data_out(o_d)
  );

  assign rejected = o_d[32];
  assign sample   = $signed(o_d[31:0]);

endmodule

### design/gbm_stage.sv
// ----------------------------------------------------------------------------
// gbm_stage - one pipeline register slot with valid
// Holds a payload and its valid bit; loads when the pipeline advances.
// ----------------------------------------------------------------------------
module gbm_stage #(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             valid_in,
  input  logic [Width-1:0] data_in,
  output logic             valid_out,
  output logic [Width-1:0] data_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (advance) begin
      valid_out <= valid_in;
    end
    if (advance) begin
      data_out <= data_in;
    end
  end

endmodule

### verif/tb_gaussian_box_muller.sv
// ----------------------------------------------------------------------------
// tb_gaussian_box_muller - self-checking bench for the Box-Muller generator
// Drives random and corner-case beats with random gaps and output stalls,
// predicts each sample with a bit-exact fixed-point model and checks results
// in order through a small scoreboard.
// ----------------------------------------------------------------------------
module tb_gaussian_box_muller
  import gbm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               rejected;
  } gauss_res_t;

  class sample_board;
    gauss_res_t pending[$];
    int         mismatches;
    int         checked;

    static function longint floor_shr(longint v, int k);
      return v >>> k;
    endfunction

    static function longint root64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    static function longint unsigned neg_log2(logic [31:0] x);
      int p;
      longint unsigned y, frac;
      frac = 0;
      p = 31;
      while (x[p] == 1'b0) p--;
      y = longint'(x) << (31 - p);
      for (int k = 23; k >= 0; k--) begin
        y = (y * y) >> 31;
        if (y >= (64'd1 << 32)) begin
          y >>= 1;
          frac |= 64'd1 << k;
        end
      end
      return (longint'(32 - p) << 24) - frac;
    endfunction

    static function longint rotate_cos(longint unsigned rad, logic [31:0] ph);
      longint x, y, z, dx, dy;
      x = longint'((rad * 64'd2608131496 + (64'd1 << 31)) >> 32);
      y = 0;
      z = longint'(ph[29:0]);
      for (int i = 0; i < CordicSteps; i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_turn(5'(i)));
        end else begin
          x += dx; y -= dy; z += longint'(atan_turn(5'(i)));
        end
      end
      case (ph[31:30])
        2'd0: return x;
        2'd1: return -y;
        2'd2: return -x;
        default: return y;
      endcase
    endfunction

    function void note_beat(logic [31:0] u1, logic [31:0] u2,
                            logic signed [23:0] mu, logic [23:0] sg);
      gauss_res_t e;
      longint unsigned l2, r2, rad;
      longint c, s;
      if (u1 == 0) begin
        e.sample = 0;
        e.rejected = 1'b1;
      end else begin
        l2 = neg_log2(u1);
        r2 = (l2 * 64'd1488522236 + (64'd1 << 25)) >> 26;
        rad = root64(r2 << 28);
        c = rotate_cos(rad, u2);
        s = longint'(mu) + floor_shr(longint'(sg) * c + (64'sd1 << 27), 28);
        e.sample = s[31:0];
        e.rejected = 1'b0;
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic signed [31:0] smp, logic rej);
      gauss_res_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: sample=%0d rej=%0b", smp, rej);
        return;
      end
      e = pending.pop_front();
      if (e.sample !== smp || e.rejected !== rej) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: exp sample=%0d rej=%0b, got sample=%0d rej=%0b",
                   checked, e.sample, e.rejected, smp, rej);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        uniform_radius = '0;
  logic [31:0]        uniform_angle = '0;
  logic signed [23:0] mean = '0;
  logic [23:0]        sigma = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] sample;
  logic               rejected;

  sample_board board = new();
  bit          stim_done = 0;
  int          cycles = 0;
  localparam int CycleLimit = 400000;

  always #4 clk = ~clk;

  gaussian_box_muller dut (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_beat(logic [31:0] u1, logic [31:0] u2,
                           logic signed [23:0] mu, logic [23:0] sg);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    uniform_radius <= u1;
    uniform_angle <= u2;
    mean <= mu;
    sigma <= sg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_beat(u1, u2, mu, sg);
  endtask

  function automatic logic [31:0] rand_radius();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'd0;
    if (r < 4) return $urandom() >> $urandom_range(0, 31);
    return $urandom();
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (!rst && out_valid && !out_stall) board.check_result(sample, rejected);
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stall_gen
    int n;
    @(negedge rst);
    forever begin
      n = gap_len();
      if (stim_done && board.pending.size() == 0) n = 0;
      out_stall <= (n > 0);
      repeat (n > 0 ? n : $urandom_range(1, 30)) @(posedge clk);
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [31:0] quads[4];
    quads = '{32'h0, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_beat(32'd0, 32'h1234_5678, 24'sh7FFFFF, 24'hFFFFFF);
    send_beat(32'd0, 32'hFFFF_FFFF, -24'sh800000, 24'h0);
    send_beat(32'd1, 32'd0, 24'sh0, 24'hFFFFFF);
    send_beat(32'd1, 32'h8000_0000, 24'sh7FFFFF, 24'hFFFFFF);
    send_beat(32'hFFFF_FFFF, 32'd0, 24'sh0, 24'h010000);
    send_beat(32'h8000_0000, 32'd0, 24'sh0, 24'h010000);
    foreach (quads[i]) send_beat(32'h1000_0000, quads[i], 24'sh0, 24'h010000);
    send_beat(32'h2000_0000, 32'h3FFF_FFFF, 24'sh0, 24'hFFFFFF);
    send_beat(32'h0000_0003, 32'hFFFF_FFFF, -24'sh800000, 24'hFFFFFF);
    send_beat(32'h7FFF_FFFF, 32'h2000_0000, -24'sh800000, 24'h0);
    send_beat(32'h0001_0000, 32'hA000_0000, 24'sh7FFFFF, 24'h800000);
    send_beat(32'hAAAA_AAAA, 32'h5555_5555, 24'sh555555, 24'hAAAAAA);
    send_beat(32'h5555_5555, 32'hAAAA_AAAA, -24'sh2AAAAB, 24'h555555);
    for (int i = 0; i < 950; i++)
      send_beat(rand_radius(), $urandom(), 24'($urandom()), 24'($urandom()));
    in_valid <= 1'b0;
    stim_done = 1;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    $display("Checked %0d samples incl. rejected draws, corner cases and random",
             board.checked);
    $display("uniforms under random input gaps and output back-pressure.");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d outstanding", board.mismatches, board.pending.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### filelist.f
design/gbm_pkg.sv
design/gbm_stage.sv
design/gaussian_box_muller.sv
verif/tb_gaussian_box_muller.sv
